/* sv/prf_pkg.sv */
// prf_pkg: shared types and codes for the policy ring FIFO.
// Used by prf_exec, policy_ring_fifo_top, prf_checker and tb_top; depends on nothing.
package prf_pkg;

	localparam int OP_W     = 3;
	localparam int STATUS_W = 3;
	localparam int CNT_W    = 32;
	localparam int TICK_W   = 32;
	localparam int CFG_IDX_W = 2;

	typedef logic [OP_W-1:0]      op_t;
	typedef logic [STATUS_W-1:0]  status_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [TICK_W-1:0]    tick_t;
	typedef logic [1:0]           policy_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// operation codes
	localparam op_t OP_PUSH    = 3'd0;
	localparam op_t OP_POP     = 3'd1;
	localparam op_t OP_PEEK    = 3'd2;
	localparam op_t OP_CONSUME = 3'd3;
	localparam op_t OP_TICK    = 3'd4;
	localparam op_t OP_CLEAR   = 3'd5;

	// status codes
	localparam status_t ST_OK      = 3'd0;
	localparam status_t ST_EMPTY   = 3'd1;
	localparam status_t ST_DROPPED = 3'd2;
	localparam status_t ST_HELD    = 3'd3;
	localparam status_t ST_TIMEOUT = 3'd4;
	localparam status_t ST_BUSY    = 3'd5;

	// full policies
	localparam policy_t POL_DROP_NEW    = 2'd0;
	localparam policy_t POL_DROP_OLDEST = 2'd1;
	localparam policy_t POL_SPIN        = 2'd2;
	localparam policy_t POL_BLOCK       = 2'd3;

	// configuration register indexes
	localparam cfg_idx_t CFG_FULL_POLICY = 2'd0;
	localparam cfg_idx_t CFG_SPIN_TICKS  = 2'd1;
	localparam cfg_idx_t CFG_BLOCK_TICKS = 2'd2;

	localparam tick_t SPIN_DEFAULT  = 32'd1024;
	localparam tick_t BLOCK_DEFAULT = 32'd4096;

	typedef struct packed {
		policy_t policy;
		tick_t   spin_ticks;
		tick_t   block_ticks;
	} cfg_t;

	typedef struct packed {
		status_t status;
		logic    data_valid;
		logic    held_accepted;
		cnt_t    pushed;
		cnt_t    popped;
		cnt_t    dropped;
	} res_t;

endpackage

/* sv/policy_ring_fifo_top.sv */
// policy_ring_fifo_top: ring FIFO with a configurable full policy.
// Depends on prf_pkg, prf_mem and prf_exec.

// At the accepting edge (start high, busy low) the opcode and record are
// captured and the head entry of the record store is read; the store is a
// synchronous memory with a registered read port. busy is high for the cycle
// after the accept, during which the operation executes; at its closing edge
// the store is written back (push or held-push entry), pointers and counters
// update, and the result is registered. done is high for exactly one cycle,
// the cycle after execution; the result stays on the result ports until the
// next operation executes. The receiver cannot stall: a result not taken while
// done is high may be replaced by the next one. A new start may be taken in
// the same cycle a result is shown, but not while busy. Configuration writes
// are always ready and should be made only while no transaction is in flight.
// The store has no clearing pass; read data is used only from written entries.
module policy_ring_fifo_top #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// command channel
	input  logic                                 start,
	output logic                                 busy,
	input  prf_pkg::op_t                         op,
	input  logic [DATA_WIDTH-1:0]                data_in,
	// result channel
	output logic                                 done,
	output prf_pkg::status_t                     status,
	output logic [DATA_WIDTH-1:0]                data_out,
	output logic                                 data_valid,
	output logic                                 held_accepted,
	output logic [$clog2(DEPTH):0]               occupancy,
	output prf_pkg::cnt_t                        pushed_count,
	output prf_pkg::cnt_t                        popped_count,
	output prf_pkg::cnt_t                        dropped_count,
	// configuration write channel
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  prf_pkg::cfg_idx_t                    cfg_index,
	input  logic [31:0]                          cfg_data
);

	localparam int IDX_W = $clog2(DEPTH);

	logic                  accept;
	logic                  go_s1;
	prf_pkg::op_t          op_s1;
	logic [DATA_WIDTH-1:0] din_s1;
	logic [DATA_WIDTH-1:0] head_data;
	logic [IDX_W-1:0]      rd_idx;
	logic                  mem_we;
	logic [IDX_W-1:0]      mem_waddr;
	logic [DATA_WIDTH-1:0] mem_wdata;
	prf_pkg::cfg_t         cfg_q;
	prf_pkg::res_t         res;

	// busy covers the execute cycle only
	assign accept    = start && !go_s1;
	assign busy      = go_s1;
	assign cfg_ready = 1'b1;

	// configuration registers; an index past the list is ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.policy      <= prf_pkg::POL_DROP_NEW;
			cfg_q.spin_ticks  <= prf_pkg::SPIN_DEFAULT;
			cfg_q.block_ticks <= prf_pkg::BLOCK_DEFAULT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				prf_pkg::CFG_FULL_POLICY: cfg_q.policy      <= cfg_data[1:0];
				prf_pkg::CFG_SPIN_TICKS:  cfg_q.spin_ticks  <= cfg_data;
				prf_pkg::CFG_BLOCK_TICKS: cfg_q.block_ticks <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// capture stage: command held alongside the head read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			go_s1 <= 1'b0;
		end else begin
			go_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1  <= op;
			din_s1 <= data_in;
		end
	end

	// Reads happen only at accept edges and writes only at execute edges,
	// so a read never overlaps a write to the same entry.
	prf_mem #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (accept),
		.raddr (rd_idx),
		.rdata (head_data)
	);

	prf_exec #(
		.DEPTH      (DEPTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_exec (
		.clk         (clk),
		.arst_n      (arst_n),
		.go_s1       (go_s1),
		.op_s1       (op_s1),
		.din_s1      (din_s1),
		.head_data   (head_data),
		.cfg         (cfg_q),
		.rd_idx      (rd_idx),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.done_q      (done),
		.res_q       (res),
		.data_out_q  (data_out),
		.occupancy_q (occupancy)
	);

	assign status        = res.status;
	assign data_valid    = res.data_valid;
	assign held_accepted = res.held_accepted;
	assign pushed_count  = res.pushed;
	assign popped_count  = res.popped;
	assign dropped_count = res.dropped;

endmodule

/* sv/prf_mem.sv */
// prf_mem: record store, one write port and one registered read port.
// Standalone; no package dependency.
module prf_mem #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [DATA_WIDTH-1:0]    wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [DATA_WIDTH-1:0]    rdata
);

	logic [DATA_WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* sv/prf_exec.sv */
// prf_exec: pointers, held push slot, statistics and the result register.
// Depends on prf_pkg; drives the write port of prf_mem.
module prf_exec #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 64,
	localparam int IDX_W     = $clog2(DEPTH),
	localparam int PTR_W     = IDX_W + 1
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  go_s1,
	input  prf_pkg::op_t          op_s1,
	input  logic [DATA_WIDTH-1:0] din_s1,
	input  logic [DATA_WIDTH-1:0] head_data,
	input  prf_pkg::cfg_t         cfg,
	output logic [IDX_W-1:0]      rd_idx,
	output logic                  mem_we,
	output logic [IDX_W-1:0]      mem_waddr,
	output logic [DATA_WIDTH-1:0] mem_wdata,
	output logic                  done_q,
	output prf_pkg::res_t         res_q,
	output logic [DATA_WIDTH-1:0] data_out_q,
	output logic [PTR_W-1:0]      occupancy_q
);

	logic [PTR_W-1:0]      rd_q, wr_q, rd_n, wr_n, lvl;
	logic                  held_valid_q, held_valid_n;
	logic [DATA_WIDTH-1:0] held_record_q;
	logic                  held_load;
	prf_pkg::tick_t        held_timer_q, held_timer_n, load_ticks;
	prf_pkg::cnt_t         pushed_q, popped_q, dropped_q;
	prf_pkg::cnt_t         pushed_n, popped_n, dropped_n;
	prf_pkg::status_t      status;
	logic                  dvalid, accepted, full, empty;
	logic [DATA_WIDTH-1:0] dout;

	assign lvl    = wr_q - rd_q;
	assign full   = (lvl == PTR_W'(DEPTH));
	assign empty  = (lvl == '0);
	assign rd_idx = rd_q[IDX_W-1:0];
	assign mem_waddr = wr_q[IDX_W-1:0];

	// zero register value falls back to the policy default
	always_comb begin
		load_ticks = (cfg.policy == prf_pkg::POL_SPIN) ? cfg.spin_ticks : cfg.block_ticks;
		if (load_ticks == '0) begin
			load_ticks = (cfg.policy == prf_pkg::POL_SPIN) ? prf_pkg::SPIN_DEFAULT
			                                               : prf_pkg::BLOCK_DEFAULT;
		end
	end

	always_comb begin
		rd_n         = rd_q;
		wr_n         = wr_q;
		held_valid_n = held_valid_q;
		held_timer_n = held_timer_q;
		held_load    = 1'b0;
		pushed_n     = pushed_q;
		popped_n     = popped_q;
		dropped_n    = dropped_q;
		status       = prf_pkg::ST_OK;
		dvalid       = 1'b0;
		accepted     = 1'b0;
		dout         = '0;
		mem_we       = 1'b0;
		mem_wdata    = din_s1;
		unique case (op_s1) inside
			prf_pkg::OP_PUSH: begin
				if (held_valid_q) begin
					status = prf_pkg::ST_BUSY;
				end else if (!full) begin
					mem_we   = 1'b1;
					wr_n     = wr_q + PTR_W'(1);
					pushed_n = pushed_q + prf_pkg::cnt_t'(1);
				end else if (cfg.policy == prf_pkg::POL_DROP_NEW) begin
					dropped_n = dropped_q + prf_pkg::cnt_t'(1);
					status    = prf_pkg::ST_DROPPED;
				end else if (cfg.policy == prf_pkg::POL_DROP_OLDEST) begin
					// head slot is the tail slot when full: overwrite it
					rd_n      = rd_q + PTR_W'(1);
					dropped_n = dropped_q + prf_pkg::cnt_t'(1);
					mem_we    = 1'b1;
					wr_n      = wr_q + PTR_W'(1);
					pushed_n  = pushed_q + prf_pkg::cnt_t'(1);
				end else begin
					held_valid_n = 1'b1;
					held_load    = 1'b1;
					held_timer_n = load_ticks;
					status       = prf_pkg::ST_HELD;
				end
			end
			prf_pkg::OP_POP, prf_pkg::OP_PEEK, prf_pkg::OP_CONSUME: begin
				if (empty) begin
					status = prf_pkg::ST_EMPTY;
				end else begin
					if (op_s1 != prf_pkg::OP_CONSUME) begin
						dout   = head_data;
						dvalid = 1'b1;
					end
					if (op_s1 != prf_pkg::OP_PEEK) begin
						rd_n     = rd_q + PTR_W'(1);
						popped_n = popped_q + prf_pkg::cnt_t'(1);
						if (held_valid_q) begin
							mem_we       = 1'b1;
							mem_wdata    = held_record_q;
							wr_n         = wr_q + PTR_W'(1);
							pushed_n     = pushed_q + prf_pkg::cnt_t'(1);
							held_valid_n = 1'b0;
							accepted     = 1'b1;
						end
					end
				end
			end
			prf_pkg::OP_TICK: begin
				if (held_valid_q) begin
					if (held_timer_q <= prf_pkg::tick_t'(1)) begin
						held_timer_n = '0;
						held_valid_n = 1'b0;
						dropped_n    = dropped_q + prf_pkg::cnt_t'(1);
						status       = prf_pkg::ST_TIMEOUT;
					end else begin
						held_timer_n = held_timer_q - prf_pkg::tick_t'(1);
						status       = prf_pkg::ST_HELD;
					end
				end
			end
			prf_pkg::OP_CLEAR: begin
				pushed_n  = '0;
				popped_n  = '0;
				dropped_n = '0;
			end
			default: begin
			end
		endcase
		if (!go_s1) begin
			mem_we = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q         <= '0;
			wr_q         <= '0;
			held_valid_q <= 1'b0;
			held_timer_q <= '0;
			pushed_q     <= '0;
			popped_q     <= '0;
			dropped_q    <= '0;
			done_q       <= 1'b0;
			res_q        <= '0;
			occupancy_q  <= '0;
		end else begin
			done_q <= go_s1;
			if (go_s1) begin
				rd_q         <= rd_n;
				wr_q         <= wr_n;
				held_valid_q <= held_valid_n;
				held_timer_q <= held_timer_n;
				pushed_q     <= pushed_n;
				popped_q     <= popped_n;
				dropped_q    <= dropped_n;
				res_q        <= '{status: status, data_valid: dvalid,
				                  held_accepted: accepted, pushed: pushed_n,
				                  popped: popped_n, dropped: dropped_n};
				occupancy_q  <= wr_n - rd_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_s1) begin
			data_out_q <= dout;
			if (held_load) begin
				held_record_q <= din_s1;
			end
		end
	end

endmodule

/* verif/prf_checker.sv */
// prf_checker: watches the command, result and register channels of the policy
// ring FIFO, predicts each result from its own copy of the FIFO and compares.
// Depends on prf_pkg.
module prf_checker #(
	parameter int DEPTH      = 256,
	parameter int DATA_WIDTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  prf_pkg::op_t           op,
	input  logic [DATA_WIDTH-1:0]  data_in,
	input  logic                   done,
	input  prf_pkg::status_t       status,
	input  logic [DATA_WIDTH-1:0]  data_out,
	input  logic                   data_valid,
	input  logic                   held_accepted,
	input  logic [$clog2(DEPTH):0] occupancy,
	input  prf_pkg::cnt_t          pushed_count,
	input  prf_pkg::cnt_t          popped_count,
	input  prf_pkg::cnt_t          dropped_count,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  prf_pkg::cfg_idx_t      cfg_index,
	input  logic [31:0]            cfg_data,
	output int                     err_count,
	output int                     pend_cnt
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PW = $clog2(DEPTH) + 1;

	typedef logic [PW-1:0]         ptr_t;
	typedef logic [DATA_WIDTH-1:0] rec_t;

	typedef struct {
		prf_pkg::status_t status;
		rec_t             data;
		logic             dvalid;
		logic             held_acc;
		ptr_t             occ;
		prf_pkg::cnt_t    pushed;
		prf_pkg::cnt_t    popped;
		prf_pkg::cnt_t    dropped;
	} fifo_res_t;

	// shadow FIFO
	rec_t             rec_mem [DEPTH];
	ptr_t             rd_ptr, wr_ptr;
	logic             hold_vld;
	rec_t             hold_rec;
	prf_pkg::tick_t   hold_left;
	prf_pkg::cnt_t    n_pushed, n_popped, n_dropped;
	prf_pkg::policy_t pol;
	prf_pkg::tick_t   spin_ticks, block_ticks;

	fifo_res_t exp_q[$];

	initial err_count = 0;

	function automatic ptr_t fill_lvl();
		return wr_ptr - rd_ptr;
	endfunction

	function automatic void store_rec(rec_t d);
		rec_mem[wr_ptr[PW-2:0]] = d;
		wr_ptr = wr_ptr + ptr_t'(1);
		n_pushed = n_pushed + prf_pkg::cnt_t'(1);
	endfunction

	// one operation against the shadow FIFO; returns the result it should give
	function automatic fifo_res_t apply_op(prf_pkg::op_t c, rec_t d);
		fifo_res_t r;
		ptr_t lvl;
		prf_pkg::tick_t hold_len;
		r = '{default: '0};
		r.status = prf_pkg::ST_OK;
		lvl = fill_lvl();
		case (c)
			prf_pkg::OP_PUSH: begin
				if (hold_vld) begin
					r.status = prf_pkg::ST_BUSY;
				end else if (lvl < ptr_t'(DEPTH)) begin
					store_rec(d);
				end else if (pol == prf_pkg::POL_DROP_NEW) begin
					n_dropped = n_dropped + prf_pkg::cnt_t'(1);
					r.status = prf_pkg::ST_DROPPED;
				end else if (pol == prf_pkg::POL_DROP_OLDEST) begin
					rd_ptr = rd_ptr + ptr_t'(1);
					n_dropped = n_dropped + prf_pkg::cnt_t'(1);
					store_rec(d);
				end else begin
					hold_len = (pol == prf_pkg::POL_SPIN) ? spin_ticks : block_ticks;
					if (hold_len == '0)
						hold_len = (pol == prf_pkg::POL_SPIN) ? prf_pkg::SPIN_DEFAULT
						                                      : prf_pkg::BLOCK_DEFAULT;
					hold_vld = 1'b1;
					hold_rec = d;
					hold_left = hold_len;
					r.status = prf_pkg::ST_HELD;
				end
			end
			prf_pkg::OP_POP, prf_pkg::OP_PEEK, prf_pkg::OP_CONSUME: begin
				if (lvl == '0) begin
					r.status = prf_pkg::ST_EMPTY;
				end else begin
					if (c != prf_pkg::OP_CONSUME) begin
						r.data = rec_mem[rd_ptr[PW-2:0]];
						r.dvalid = 1'b1;
					end
					if (c != prf_pkg::OP_PEEK) begin
						rd_ptr = rd_ptr + ptr_t'(1);
						n_popped = n_popped + prf_pkg::cnt_t'(1);
						// a freed slot lets the held push in
						if (hold_vld) begin
							store_rec(hold_rec);
							hold_vld = 1'b0;
							r.held_acc = 1'b1;
						end
					end
				end
			end
			prf_pkg::OP_TICK: begin
				if (hold_vld) begin
					if (hold_left <= prf_pkg::tick_t'(1)) begin
						hold_left = '0;
						hold_vld = 1'b0;
						n_dropped = n_dropped + prf_pkg::cnt_t'(1);
						r.status = prf_pkg::ST_TIMEOUT;
					end else begin
						hold_left = hold_left - prf_pkg::tick_t'(1);
						r.status = prf_pkg::ST_HELD;
					end
				end
			end
			prf_pkg::OP_CLEAR: begin
				n_pushed = '0;
				n_popped = '0;
				n_dropped = '0;
			end
			default: ;
		endcase
		r.occ = fill_lvl();
		r.pushed = n_pushed;
		r.popped = n_popped;
		r.dropped = n_dropped;
		return r;
	endfunction

	// prints one line per mismatch and counts every one
	task automatic report_err(string what);
		err_count++;
		$display("prf_checker: %0t: %s", $time, what);
	endtask

	task automatic cmp_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want)
			report_err($sformatf("%s expected %0h got %0h", name, want, got));
	endtask

	always @(posedge clk or negedge arst_n) begin
		fifo_res_t want;
		if (!arst_n) begin
			rd_ptr = '0;
			wr_ptr = '0;
			hold_vld = 1'b0;
			hold_rec = '0;
			hold_left = '0;
			n_pushed = '0;
			n_popped = '0;
			n_dropped = '0;
			pol = prf_pkg::POL_DROP_NEW;
			spin_ticks = prf_pkg::SPIN_DEFAULT;
			block_ticks = prf_pkg::BLOCK_DEFAULT;
			exp_q.delete();
			pend_cnt <= 0;
		end else begin
			if (done) begin
				if (exp_q.size() == 0) begin
					report_err("result with no transaction outstanding");
				end else begin
					want = exp_q.pop_front();
					cmp_field("status", want.status, status);
					cmp_field("data_out", want.data, data_out);
					cmp_field("data_valid", want.dvalid, data_valid);
					cmp_field("held_accepted", want.held_acc, held_accepted);
					cmp_field("occupancy", want.occ, occupancy);
					cmp_field("pushed_count", want.pushed, pushed_count);
					cmp_field("popped_count", want.popped, popped_count);
					cmp_field("dropped_count", want.dropped, dropped_count);
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					prf_pkg::CFG_FULL_POLICY: pol = cfg_data[1:0];
					prf_pkg::CFG_SPIN_TICKS:  spin_ticks = cfg_data;
					prf_pkg::CFG_BLOCK_TICKS: block_ticks = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy)
				exp_q.push_back(apply_op(op, data_in));
			pend_cnt <= exp_q.size();
		end
	end

endmodule

/* verif/tb_top.sv */
// tb_top: stimulus and verdict for policy_ring_fifo_top.
// Depends on prf_pkg, the FIFO RTL and prf_checker, which does all prediction.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DEPTH = 256;
	localparam int DW    = 64;

	// op codes the block treats as no-ops
	localparam prf_pkg::op_t OP_SPARE6 = 3'd6;
	localparam prf_pkg::op_t OP_SPARE7 = 3'd7;

	// every input has a known value from time zero
	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   start     = 1'b0;
	prf_pkg::op_t           op        = prf_pkg::OP_TICK;
	logic [DW-1:0]          data_in   = '0;
	logic                   cfg_valid = 1'b0;
	prf_pkg::cfg_idx_t      cfg_index = prf_pkg::CFG_FULL_POLICY;
	logic [31:0]            cfg_data  = '0;

	logic                   busy;
	logic                   done;
	prf_pkg::status_t       status;
	logic [DW-1:0]          data_out;
	logic                   data_valid;
	logic                   held_accepted;
	logic [$clog2(DEPTH):0] occupancy;
	prf_pkg::cnt_t          pushed_count;
	prf_pkg::cnt_t          popped_count;
	prf_pkg::cnt_t          dropped_count;
	logic                   cfg_ready;

	int                     err_count;
	int                     pend_cnt;

	// occupancy from the latest result, used only to steer the op mix
	logic [$clog2(DEPTH):0] last_occ = '0;
	// when set, the command side issues back to back
	bit                     quiet = 1'b0;

	prf_pkg::policy_t       phase_pol;
	int                     n_drain;

	policy_ring_fifo_top #(.DEPTH(DEPTH), .DATA_WIDTH(DW)) dut (.*);

	prf_checker #(.DEPTH(DEPTH), .DATA_WIDTH(DW)) chk (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk)
		if (done)
			last_occ <= occupancy;

	// hard stop in case the block hangs or drops results
	initial begin
		#5_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	// mostly no gap, some short, a few long
	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (quiet || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 30);
	endfunction

	function automatic logic [DW-1:0] rand_rec();
		int r;
		r = $urandom_range(99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		return {$urandom, $urandom};
	endfunction

	// push-heavy below the target fill, balanced once there, so the FIFO
	// hovers at the target and the full/empty paths get hit often
	function automatic prf_pkg::op_t pick_op(int tgt);
		int r;
		r = $urandom_range(99);
		if (r < ((last_occ < tgt) ? 60 : 35))
			return prf_pkg::OP_PUSH;
		r = $urandom_range(99);
		if (r < 40)
			return prf_pkg::OP_POP;
		if (r < 60)
			return prf_pkg::OP_CONSUME;
		if (r < 72)
			return prf_pkg::OP_PEEK;
		if (r < 94)
			return prf_pkg::OP_TICK;
		if (r < 97)
			return prf_pkg::OP_CLEAR;
		return (r[0]) ? OP_SPARE7 : OP_SPARE6;
	endfunction

	// one command transaction, then a random idle gap
	task automatic run_op(prf_pkg::op_t c, logic [DW-1:0] d);
		int g;
		start <= 1'b1;
		op <= c;
		data_in <= d;
		do @(posedge clk); while (busy);
		g = gap_len();
		if (g > 0) begin
			start <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	// stop issuing and wait until every result has come back
	task automatic settle();
		start <= 1'b0;
		@(posedge clk);
		while (pend_cnt != 0)
			@(posedge clk);
	endtask

	// register writes only happen with the block idle
	task automatic write_reg(prf_pkg::cfg_idx_t idx, logic [31:0] v);
		settle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic fill_up();
		int n;
		settle();
		n = DEPTH - int'(last_occ);
		repeat (n) run_op(prf_pkg::OP_PUSH, rand_rec());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- empty FIFO: refusals, no-ops, data extremes ---
		run_op(prf_pkg::OP_POP, rand_rec());
		run_op(prf_pkg::OP_PEEK, rand_rec());
		run_op(prf_pkg::OP_CONSUME, rand_rec());     // consume on empty is refused
		run_op(prf_pkg::OP_TICK, rand_rec());        // nothing held
		run_op(OP_SPARE6, rand_rec());
		run_op(OP_SPARE7, rand_rec());
		run_op(prf_pkg::OP_PUSH, '0);
		run_op(prf_pkg::OP_PUSH, '1);
		run_op(prf_pkg::OP_PUSH, {32{2'b10}});
		run_op(prf_pkg::OP_PUSH, {32{2'b01}});
		run_op(prf_pkg::OP_PEEK, rand_rec());
		run_op(prf_pkg::OP_POP, rand_rec());
		run_op(prf_pkg::OP_CONSUME, rand_rec());
		run_op(prf_pkg::OP_POP, rand_rec());
		run_op(prf_pkg::OP_POP, rand_rec());
		run_op(prf_pkg::OP_POP, rand_rec());         // empty again
		run_op(prf_pkg::OP_CLEAR, rand_rec());

		// --- full FIFO under each policy ---
		fill_up();
		write_reg(prf_pkg::CFG_FULL_POLICY, 32'(prf_pkg::POL_DROP_NEW));
		run_op(prf_pkg::OP_PUSH, rand_rec());        // refused, counted as dropped
		write_reg(prf_pkg::CFG_FULL_POLICY, 32'(prf_pkg::POL_DROP_OLDEST));
		run_op(prf_pkg::OP_PUSH, rand_rec());        // head goes, new record stored
		run_op(prf_pkg::OP_PEEK, rand_rec());        // peek still allowed

		write_reg(prf_pkg::CFG_SPIN_TICKS, 32'd2);
		write_reg(prf_pkg::CFG_FULL_POLICY, 32'(prf_pkg::POL_SPIN));
		run_op(prf_pkg::OP_PUSH, rand_rec());        // held
		run_op(prf_pkg::OP_PUSH, rand_rec());        // second push while held: busy
		run_op(prf_pkg::OP_TICK, rand_rec());
		run_op(prf_pkg::OP_TICK, rand_rec());        // timer runs out
		run_op(prf_pkg::OP_PUSH, rand_rec());
		run_op(prf_pkg::OP_POP, rand_rec());         // held record enters

		write_reg(prf_pkg::CFG_BLOCK_TICKS, 32'd1);
		write_reg(prf_pkg::CFG_FULL_POLICY, 32'(prf_pkg::POL_BLOCK));
		run_op(prf_pkg::OP_PUSH, rand_rec());
		run_op(prf_pkg::OP_TICK, rand_rec());        // shortest timeout

		// policy change while a push is held keeps its timer
		write_reg(prf_pkg::CFG_BLOCK_TICKS, 32'hFFFF_FFFF);
		run_op(prf_pkg::OP_PUSH, rand_rec());
		write_reg(prf_pkg::CFG_FULL_POLICY, 32'(prf_pkg::POL_DROP_NEW));
		run_op(prf_pkg::OP_TICK, rand_rec());
		run_op(prf_pkg::OP_CONSUME, rand_rec());     // consume also lets it in

		// zero register value falls back to the reset value
		write_reg(prf_pkg::CFG_BLOCK_TICKS, 32'd0);
		write_reg(prf_pkg::CFG_FULL_POLICY, 32'(prf_pkg::POL_BLOCK));
		run_op(prf_pkg::OP_PUSH, rand_rec());
		run_op(prf_pkg::OP_POP, rand_rec());
		write_reg(prf_pkg::CFG_SPIN_TICKS, 32'd0);
		write_reg(prf_pkg::CFG_FULL_POLICY, 32'(prf_pkg::POL_SPIN));
		run_op(prf_pkg::OP_PUSH, rand_rec());
		// last one times out
		repeat (int'(prf_pkg::SPIN_DEFAULT)) run_op(prf_pkg::OP_TICK, rand_rec());
		run_op(prf_pkg::OP_CLEAR, rand_rec());

		// --- random phases: one per policy near full, then mixed, then near empty ---
		for (int ph = 0; ph < 6; ph++) begin
			phase_pol = (ph < 4) ? prf_pkg::policy_t'(ph)
			                     : prf_pkg::policy_t'($urandom_range(3));
			write_reg(prf_pkg::CFG_SPIN_TICKS,
				(ph == 0) ? 32'd1 : (ph == 1) ? 32'hFFFF_FFFF : 32'($urandom_range(2, 12)));
			write_reg(prf_pkg::CFG_BLOCK_TICKS,
				(ph == 2) ? 32'd1 : (ph == 3) ? 32'hFFFF_FFFF : 32'($urandom_range(2, 12)));
			write_reg(prf_pkg::CFG_FULL_POLICY, 32'(phase_pol));
			quiet = ($urandom_range(3) == 0);
			if (ph == 5) begin
				// drain first so the last phase lives around empty
				settle();
				n_drain = int'(last_occ);
				repeat (n_drain)
					run_op(($urandom_range(1)) ? prf_pkg::OP_POP : prf_pkg::OP_CONSUME,
						rand_rec());
			end
			repeat (35)
				run_op(pick_op((ph == 5) ? 4 : DEPTH), rand_rec());
		end

		// all results in, then an idle wait for anything stray
		settle();
		repeat (4) @(posedge clk);
		if (err_count == 0 && pend_cnt == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule
